### hdl/page_framebuffer_pixel_engine_unit_macros.svh
// Assertion helpers for the RTL.
`ifndef PAGE_FRAMEBUFFER_PIXEL_ENGINE_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_PIXEL_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define PFPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pfpe_pkg.sv
package pfpe_pkg;

  localparam int MaxWidth   = 128;
  localparam int MaxPages   = 16;
  localparam int StoreDepth = MaxWidth * MaxPages;
  localparam int AddrW      = $clog2(StoreDepth);
  // w (8b) * page (5b) + column (8b)
  localparam int ProdW      = 14;

  localparam logic [7:0] WidthReset  = 8'd128;
  localparam logic [7:0] HeightReset = 8'd64;

  localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ROTATION     = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    COL_CLEAR  = 2'd0,
    COL_SET    = 2'd1,
    COL_TOGGLE = 2'd2,
    COL_KEEP   = 2'd3
  } color_e;

  typedef struct packed {
    logic load_in;
    logic map_en;
    logic addr_en;
    logic mem_rd;
    logic mem_wr;
    logic clr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_last;
  } sts_t;

endpackage

### hdl/pfpe_if.sv
interface pfpe_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic        [1:0]  pixel_color;
  logic        [3:0]  page_sel;
  logic        [6:0]  column_sel;

  modport source (
    output valid, opcode, x_pos, y_pos, pixel_color, page_sel, column_sel,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_pos, y_pos, pixel_color, page_sel, column_sel,
    output ready
  );
endinterface

interface pfpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       status;

  modport source (output valid, read_data, status, input ready);
  modport sink (input valid, read_data, status, output ready);
endinterface

interface pfpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/pfpe_ram.sv
module pfpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pfpe_ctrl.sv
module pfpe_ctrl import pfpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAP  = 7'b0000010,
    S_ADDR = 7'b0000100,
    S_READ = 7'b0001000,
    S_MOD  = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_MAP;
        end
      end
      S_MAP: begin
        if (sts_i.op == OP_CLEAR) begin
          state_d = S_CLR;
        end else begin
          cmd_o.map_en = 1'b1;
          state_d      = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.addr_en = 1'b1;
        state_d       = S_READ;
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = S_RESP;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/pfpe_dpath.sv
module pfpe_dpath import pfpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic        [1:0]  opcode_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic        [1:0]  pixel_color_i,
  input  logic        [3:0]  page_sel_i,
  input  logic        [6:0]  column_sel_i,
  input  logic               cfg_we_i,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [7:0]  cfg_data_i,
  output logic        [7:0]  read_data_o,
  output logic               status_o
);

  // configuration
  logic [7:0] width_q, height_q;
  logic [1:0] rot_q;

  // captured transaction
  op_e               op_q;
  logic signed [15:0] x_q, y_q;
  color_e            color_q;
  logic        [3:0] page_sel_q;
  logic        [6:0] col_sel_q;

  // map stage
  logic [7:0] col_q, col_d;
  logic [4:0] page_q, page_d;
  logic [2:0] bit_q, bit_d;
  logic       ok_q, ok_d;

  // address stage
  logic [AddrW-1:0] addr_q;
  logic             hit_q;
  logic [ProdW-1:0] sum;

  // clear sweep
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  // result
  logic [7:0] read_data_q;
  logic       status_q;

  // memory port
  logic             mem_en, mem_we, plot_wr;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata, mask, mod_byte;

  logic [7:0] rw, rh, x8, y8, px, py;
  logic       in_rng;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      rot_q    <= ROT_0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PANEL_WIDTH:  width_q  <= cfg_data_i;
        CFG_PANEL_HEIGHT: height_q <= cfg_data_i;
        CFG_ROTATION:     rot_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q       <= op_e'(opcode_i);
      x_q        <= x_pos_i;
      y_q        <= y_pos_i;
      color_q    <= color_e'(pixel_color_i);
      page_sel_q <= page_sel_i;
      col_sel_q  <= column_sel_i;
    end
  end

  always_comb begin
    rw     = rot_q[0] ? height_q : width_q;
    rh     = rot_q[0] ? width_q : height_q;
    x8     = x_q[7:0];
    y8     = y_q[7:0];
    in_rng = !x_q[15] && !y_q[15] && (x_q[14:0] < {7'd0, rw}) && (y_q[14:0] < {7'd0, rh});
    case (rot_q)
      ROT_90: begin
        px = width_q - 8'd1 - y8;
        py = x8;
      end
      ROT_180: begin
        px = width_q - 8'd1 - x8;
        py = height_q - 8'd1 - y8;
      end
      ROT_270: begin
        px = y8;
        py = height_q - 8'd1 - x8;
      end
      default: begin
        px = x8;
        py = y8;
      end
    endcase
    col_d  = px;
    page_d = py[7:3];
    bit_d  = py[2:0];
    ok_d   = 1'b0;
    case (op_q)
      OP_PLOT: ok_d = in_rng;
      OP_READ: begin
        col_d  = {1'b0, col_sel_q};
        page_d = {1'b0, page_sel_q};
        ok_d   = ({1'b0, col_sel_q} < width_q) && ({1'b0, page_sel_q} < height_q[7:3]);
      end
      default: ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_en) begin
      col_q  <= col_d;
      page_q <= page_d;
      bit_q  <= bit_d;
      ok_q   <= ok_d;
    end
  end

  assign sum = (ProdW'(width_q) * ProdW'(page_q)) + ProdW'(col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_en) begin
      addr_q <= sum[AddrW-1:0];
      hit_q  <= ok_q && (sum < ProdW'(StoreDepth));
    end
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.load_in) begin
      clr_cnt_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    mask = 8'd1 << bit_q;
    case (color_q)
      COL_CLEAR:  mod_byte = mem_rdata & ~mask;
      COL_SET:    mod_byte = mem_rdata | mask;
      COL_TOGGLE: mod_byte = mem_rdata ^ mask;
      default:    mod_byte = mem_rdata;
    endcase
  end

  assign plot_wr   = cmd_i.mem_wr && (op_q == OP_PLOT) && hit_q && (color_q != COL_KEEP);
  assign mem_en    = cmd_i.mem_rd || plot_wr || cmd_i.clr_step;
  assign mem_we    = plot_wr || cmd_i.clr_step;
  assign mem_addr  = cmd_i.clr_step ? clr_cnt_q : addr_q;
  assign mem_wdata = cmd_i.clr_step ? 8'h00 : mod_byte;

  pfpe_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_q <= ((op_q == OP_READ) && hit_q) ? mem_rdata : 8'h00;
      status_q    <= (op_q == OP_PLOT) && !hit_q;
    end
  end

  assign read_data_o    = read_data_q;
  assign status_o       = status_q;
  assign sts_o.op       = op_q;
  assign sts_o.clr_last = (clr_cnt_q == AddrW'(StoreDepth - 1));

endmodule

### hdl/page_framebuffer_pixel_engine_unit.sv
// Channel  Dir  Handshake    Payload
// in_i     in   valid/ready  opcode, x_pos, y_pos, pixel_color, page_sel, column_sel
// out_o    out  valid/ready  read_data, status
// cfg_i    in   valid/ready  index, data (ready always high)
//
// Plot, read and no-op run through the map / address / read / modify steps on the
// single-port frame store, then the response step.
// Clear: the whole frame store is swept, one byte zeroed per cycle.
// Reset clears control and config registers; frame store contents stay undefined.
// A held result stalls the engine only at its final step.
`include "page_framebuffer_pixel_engine_unit_macros.svh"

module page_framebuffer_pixel_engine_unit import pfpe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  pfpe_in_if.sink   in_i,
  pfpe_out_if.source out_o,
  pfpe_cfg_if.sink  cfg_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  pfpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pfpe_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_i.opcode),
    .x_pos_i       (in_i.x_pos),
    .y_pos_i       (in_i.y_pos),
    .pixel_color_i (in_i.pixel_color),
    .page_sel_i    (in_i.page_sel),
    .column_sel_i  (in_i.column_sel),
    .cfg_we_i      (cfg_i.valid && cfg_i.ready),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .read_data_o   (out_o.read_data),
    .status_o      (out_o.status)
  );

  `PFPE_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "accepted while busy")
  `PFPE_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, cmd.load_out, !out_o.valid || out_o.ready, "pending result overwritten")
  `PFPE_ASSERT_NEXT(a_rmw_order, clk_i, rst_ni, cmd.mem_rd, cmd.mem_wr, "modify does not follow read")

endmodule

### dv/pfpe_tb_pkg.sv
`timescale 1ns / 100ps

package pfpe_tb_pkg;
  import pfpe_pkg::*;

  typedef struct {
    op_e                op;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    color_e             color;
    logic        [3:0]  page;
    logic        [6:0]  column;
  } fb_cmd_t;

  typedef struct {
    logic [7:0] read_data;
    logic       status;
  } fb_reply_t;

  class frame_scoreboard;
    logic [7:0] frame_mirror [StoreDepth];
    int         panel_w;
    int         panel_h;
    logic [1:0] rotation;
    fb_reply_t  reply_q [$];
    int         n_plot;
    int         n_read;
    int         n_clear;
    int         n_nop;
    int         n_checked;
    int         n_flagged;
    int         n_errors;

    function new();
      panel_w   = WidthReset;
      panel_h   = HeightReset;
      rotation  = ROT_0;
      n_plot    = 0;
      n_read    = 0;
      n_clear   = 0;
      n_nop     = 0;
      n_checked = 0;
      n_flagged = 0;
      n_errors  = 0;
      foreach (frame_mirror[i]) frame_mirror[i] = '0;
    endfunction

    function void write_reg(logic [1:0] index, logic [7:0] value);
      case (index)
        CFG_PANEL_WIDTH:  panel_w = int'(value);
        CFG_PANEL_HEIGHT: panel_h = int'(value);
        CFG_ROTATION:     rotation = value[1:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the pixel is off the panel or past the store
    function logic plot_pixel(int x, int y, color_e color);
      int         rw;
      int         rh;
      int         px;
      int         py;
      int         addr;
      logic [7:0] mask;
      rw = rotation[0] ? panel_h : panel_w;
      rh = rotation[0] ? panel_w : panel_h;
      if (x < 0 || x >= rw || y < 0 || y >= rh) return 1'b1;
      case (rotation)
        ROT_90: begin
          px = panel_w - 1 - y;
          py = x;
        end
        ROT_180: begin
          px = panel_w - 1 - x;
          py = panel_h - 1 - y;
        end
        ROT_270: begin
          px = y;
          py = panel_h - 1 - x;
        end
        default: begin
          px = x;
          py = y;
        end
      endcase
      addr = panel_w * (py / 8) + px;
      if (addr >= StoreDepth) return 1'b1;
      mask = 8'(1 << (py % 8));
      case (color)
        COL_CLEAR:  frame_mirror[addr] = frame_mirror[addr] & ~mask;
        COL_SET:    frame_mirror[addr] = frame_mirror[addr] | mask;
        COL_TOGGLE: frame_mirror[addr] = frame_mirror[addr] ^ mask;
        default: ;
      endcase
      return 1'b0;
    endfunction

    function logic [7:0] fetch_byte(int page, int column);
      int addr;
      if (column >= panel_w || page >= panel_h / 8) return '0;
      addr = page * panel_w + column;
      if (addr >= StoreDepth) return '0;
      return frame_mirror[addr];
    endfunction

    function void note_command(fb_cmd_t c);
      fb_reply_t r;
      r.read_data = '0;
      r.status    = 1'b0;
      case (c.op)
        OP_PLOT: begin
          n_plot++;
          r.status = plot_pixel(int'(c.x_pos), int'(c.y_pos), c.color);
        end
        OP_READ: begin
          n_read++;
          r.read_data = fetch_byte(int'(c.page), int'(c.column));
        end
        OP_CLEAR: begin
          n_clear++;
          foreach (frame_mirror[i]) frame_mirror[i] = '0;
        end
        default: n_nop++;
      endcase
      reply_q.push_back(r);
    endfunction

    function void check_reply(logic [7:0] read_data, logic status);
      fb_reply_t want;
      n_checked++;
      if (status === 1'b1) n_flagged++;
      if (reply_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected result read_data %02h status %0b",
                   $time, read_data, status);
        return;
      end
      want = reply_q.pop_front();
      if (read_data !== want.read_data || status !== want.status) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: mismatch read_data exp %02h got %02h, status exp %0b got %0b",
                   $time, want.read_data, read_data, want.status, status);
      end
    endfunction

    function int pending();
      return reply_q.size();
    endfunction
  endclass

endpackage

### dv/page_framebuffer_pixel_engine_unit_test.sv
`timescale 1ns / 100ps

module page_framebuffer_pixel_engine_unit_test;
  import pfpe_pkg::*;
  import pfpe_tb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int SettleCycles  = 12;
  localparam int PhaseCount    = 9;
  localparam int PhaseItems    = 86;
  localparam int PhaseW [8] = '{128, 128, 8, 128, 255, 0, 100, 37};
  localparam int PhaseH [8] = '{64, 128, 8, 64, 255, 0, 60, 23};
  localparam int PhaseR [8] = '{0, 1, 2, 3, 1, 0, 2, 3};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfpe_in_if  cmd_if ();
  pfpe_out_if res_if ();
  pfpe_cfg_if reg_if ();

  page_framebuffer_pixel_engine_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if),
    .out_o (res_if),
    .cfg_i (reg_if)
  );

  frame_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;
  int idle_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready)
        sb.check_reply(res_if.read_data, res_if.status);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic fb_cmd_t make_cmd(op_e op, int x, int y, color_e color,
                                       int page, int column);
    fb_cmd_t c;
    c.op     = op;
    c.x_pos  = 16'(x);
    c.y_pos  = 16'(y);
    c.color  = color;
    c.page   = 4'(page);
    c.column = 7'(column);
    return c;
  endfunction

  function automatic fb_cmd_t random_command();
    fb_cmd_t c;
    int      rw;
    int      rh;
    int      roll;
    rw   = sb.rotation[0] ? sb.panel_h : sb.panel_w;
    rh   = sb.rotation[0] ? sb.panel_w : sb.panel_h;
    roll = $urandom_range(99);
    if (roll < 60) c.op = OP_PLOT;
    else if (roll < 88) c.op = OP_READ;
    else if (roll < 90) c.op = OP_CLEAR;
    else c.op = OP_NOP;
    c.x_pos  = 16'($urandom);
    c.y_pos  = 16'($urandom);
    c.color  = color_e'($urandom_range(3));
    c.page   = 4'($urandom);
    c.column = 7'($urandom);
    // mostly stay on or just around the panel
    if ($urandom_range(9) < 8) begin
      c.x_pos  = 16'(int'($urandom_range(rw + 1)) - 1);
      c.y_pos  = 16'(int'($urandom_range(rh + 1)) - 1);
      c.page   = 4'($urandom_range(sb.panel_h / 8 > 15 ? 15 : sb.panel_h / 8));
      c.column = 7'($urandom_range(sb.panel_w > 127 ? 127 : sb.panel_w));
    end
    return c;
  endfunction

  task automatic issue_command(fb_cmd_t c);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= c.op;
    cmd_if.x_pos       <= c.x_pos;
    cmd_if.y_pos       <= c.y_pos;
    cmd_if.pixel_color <= c.color;
    cmd_if.page_sel    <= c.page;
    cmd_if.column_sel  <= c.column;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_panel(int w, int h, logic [1:0] rot);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_PANEL_WIDTH, CFG_PANEL_HEIGHT, CFG_ROTATION};
    val = '{8'(w), 8'(h), {6'b0, rot}};
    for (int i = 0; i < 3; i++) begin
      reg_if.valid <= 1'b1;
      reg_if.index <= idx[i];
      reg_if.data  <= val[i];
      @(posedge clk);
      while (!reg_if.ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    reg_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    // store is undefined until the first clear
    issue_command(make_cmd(OP_NOP, -1, -1, COL_KEEP, 15, 127));
    issue_command(make_cmd(OP_CLEAR, 0, 0, COL_CLEAR, 0, 0));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 0, 0));
    issue_command(make_cmd(OP_PLOT, 0, 0, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 127, 63, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 127, 0, COL_TOGGLE, 0, 0));
    issue_command(make_cmd(OP_PLOT, 0, 63, COL_KEEP, 0, 0));
    issue_command(make_cmd(OP_PLOT, 5, 9, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 5, 10, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 5, 9, COL_TOGGLE, 0, 0));
    issue_command(make_cmd(OP_PLOT, 5, 10, COL_CLEAR, 0, 0));
    issue_command(make_cmd(OP_PLOT, 5, 11, COL_TOGGLE, 0, 0));
    // off-panel plots, flagged whatever the color
    issue_command(make_cmd(OP_PLOT, 128, 0, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 0, 64, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, -1, 0, COL_SET, 0, 0));
    issue_command(make_cmd(OP_PLOT, 0, -1, COL_TOGGLE, 0, 0));
    issue_command(make_cmd(OP_PLOT, -32768, 32767, COL_KEEP, 0, 0));
    issue_command(make_cmd(OP_PLOT, 32767, -32768, COL_TOGGLE, 0, 0));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 0, 0));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 7, 127));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 1, 5));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 0, 127));
    issue_command(make_cmd(OP_READ, 0, 0, COL_CLEAR, 8, 0));
    issue_command(make_cmd(OP_READ, -1, -1, COL_KEEP, 15, 127));
    cmd_if.valid <= 1'b0;
  endtask

  initial begin
    int w;
    int h;
    int r;
    cmd_if.valid       <= 1'b0;
    cmd_if.opcode      <= OP_NOP;
    cmd_if.x_pos       <= '0;
    cmd_if.y_pos       <= '0;
    cmd_if.pixel_color <= COL_KEEP;
    cmd_if.page_sel    <= '0;
    cmd_if.column_sel  <= '0;
    reg_if.valid       <= 1'b0;
    reg_if.index       <= CFG_PANEL_WIDTH;
    reg_if.data        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < PhaseCount; p++) begin
      wait_drained();
      if (p < 8) begin
        w = PhaseW[p];
        h = PhaseH[p];
        r = PhaseR[p];
      end else begin
        w = $urandom_range(255);
        h = $urandom_range(255);
        r = $urandom_range(3);
      end
      program_panel(w, h, 2'(r));
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          // long back-pressure so the engine fills and stalls its input
          hold_cycles  = 400;
        end
        1: begin
          tx_idle_pct  = 49;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 49;
        end
        default: begin
          tx_idle_pct  = 10;
          rx_stall_pct = 10;
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) issue_command(random_command());
      cmd_if.valid <= 1'b0;
    end

    wait_drained();
    rx_stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);

    $display("Ran %0d plots, %0d reads, %0d clears and %0d no-ops over %0d panel settings.",
             sb.n_plot, sb.n_read, sb.n_clear, sb.n_nop, PhaseCount + 1);
    $display("Checked %0d results, %0d off-panel plots flagged, %0d mismatches, %0d missing.",
             sb.n_checked, sb.n_flagged, sb.n_errors, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/pfpe_pkg.sv
hdl/pfpe_if.sv
hdl/pfpe_ram.sv
hdl/pfpe_ctrl.sv
hdl/pfpe_dpath.sv
hdl/page_framebuffer_pixel_engine_unit.sv
dv/pfpe_tb_pkg.sv
dv/page_framebuffer_pixel_engine_unit_test.sv
